/* src/bayer_quad_to_rgb_gain_assert.svh */
// Assertion macros shared by the RTL of the Bayer quad converter.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef BAYER_QUAD_TO_RGB_GAIN_ASSERT_SVH
`define BAYER_QUAD_TO_RGB_GAIN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQRG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BQRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bqrg_pkg.sv */
`default_nettype none

package bqrg_pkg;

    // Sample width of the Bayer quad.
    localparam int SAMPLE_BITS = 12;

    // Logarithm datapath: Q16 fraction, Q30 mantissa held in 31 bits.
    localparam int FRAC_BITS   = 16;
    localparam int MANT_BITS   = 31;
    localparam int K_BITS      = 21;
    localparam int ROUND_SHIFT = 32;

    // Normalize stage, one squaring stage per fraction bit, multiply stage.
    localparam int LOG_STAGES  = FRAC_BITS + 2;

    // Input register, log stages, output register.
    localparam int STAGES      = LOG_STAGES + 2;

    // Scale constants c*ln2*65536 for red/blue and for the green sum.
    localparam logic [K_BITS-1:0] LOG_K_RB = 21'd1392673;
    localparam logic [K_BITS-1:0] LOG_K_G  = 21'd1285513;

    // Gain mode: codes below this are linear, this and above logarithmic.
    localparam int MODE_BITS = 3;
    localparam logic [MODE_BITS-1:0] MODE_LOG      = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_LIN_BASE = 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = MODE_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RED_ENABLE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_ENABLE = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_ENABLE  = 2'd3;

    // One Bayer quad.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] green_top;
        logic [SAMPLE_BITS-1:0] red_sample;
        logic [SAMPLE_BITS-1:0] blue_sample;
        logic [SAMPLE_BITS-1:0] green_bottom;
    } quad_t;

    // One RGB pixel.
    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } pixel_t;

    // Saturate a linear result at 255.
    function automatic logic [7:0] sat8(input logic [SAMPLE_BITS+1:0] v);
        logic [7:0] r;
        r = (v > (SAMPLE_BITS+2)'(255)) ? 8'hFF : v[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/bqrg_linear.sv */
`default_nettype none

// Linear gain: each channel divided by a power of two with rounding to nearest.
module bqrg_linear (
    input  wire logic [bqrg_pkg::MODE_BITS-1:0] gain_mode,
    input  wire bqrg_pkg::quad_t                quad,
    output bqrg_pkg::pixel_t                    pixel
);

    localparam int SW = bqrg_pkg::SAMPLE_BITS;

    logic [bqrg_pkg::MODE_BITS-1:0] shift;
    logic [SW:0]   rnd;
    logic [SW:0]   red_sum;
    logic [SW:0]   blue_sum;
    logic [SW+1:0] green_sum;

    // The divisor is 2^shift; green divides the sum of two samples by twice that.
    always_comb
    begin
        shift = bqrg_pkg::MODE_LIN_BASE - gain_mode;
        rnd   = (shift == '0) ? '0 : ((SW+1)'(1) << (shift - 1'b1));
        red_sum   = {1'b0, quad.red_sample} + rnd;
        blue_sum  = {1'b0, quad.blue_sample} + rnd;
        green_sum = (SW+2)'(quad.green_top) + (SW+2)'(quad.green_bottom)
                  + ((SW+2)'(1) << shift);
        pixel.red_out   = bqrg_pkg::sat8((SW+2)'(red_sum >> shift));
        pixel.blue_out  = bqrg_pkg::sat8((SW+2)'(blue_sum >> shift));
        pixel.green_out = bqrg_pkg::sat8(green_sum >> (shift + 1'b1));
    end

endmodule

`default_nettype wire

/* src/bqrg_log_unit.sv */
`default_nettype none

// Pipelined scaled logarithm: round(K * log2(max(1,v)) / 2^16), saturated at 255.
// The fraction bits come from repeated squaring of the normalized mantissa,
// one squaring per stage.
module bqrg_log_unit #(
    parameter int                               VALUE_BITS = bqrg_pkg::SAMPLE_BITS,
    parameter logic [bqrg_pkg::K_BITS-1:0]      LOG_K      = bqrg_pkg::LOG_K_RB
) (
    input  wire logic                              clk,
    input  wire logic [bqrg_pkg::LOG_STAGES-1:0]   en,
    input  wire logic [VALUE_BITS-1:0]             value,
    output logic [7:0]                             log_out
);

    localparam int FB = bqrg_pkg::FRAC_BITS;
    localparam int MW = bqrg_pkg::MANT_BITS;
    localparam int NW = $clog2(VALUE_BITS);
    localparam int LW = NW + FB;
    localparam int PW = LW + bqrg_pkg::K_BITS;
    localparam int RS = bqrg_pkg::ROUND_SHIFT;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (RS - 1);

    logic [VALUE_BITS-1:0] v_clip;
    logic [NW-1:0]         lead;
    logic [MW-1:0]         mant;

    logic [MW-1:0] y_reg    [0:FB];
    logic [FB-1:0] frac_reg [0:FB];
    logic [NW-1:0] n_reg    [0:FB];
    logic [PW-1:0] prod_reg;
    logic [PW:0]   rounded;

    // Leading one and normalization of the mantissa into [1,2) in Q30.
    always_comb
    begin
        v_clip = (value == '0) ? VALUE_BITS'(1) : value;
        lead   = '0;
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (v_clip[i])
            begin
                lead = NW'(i);
            end
        end
        mant = MW'(v_clip) << (MW - 1 - int'(lead));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            y_reg[0]    <= mant;
            frac_reg[0] <= '0;
            n_reg[0]    <= lead;
        end
    end

    // One squaring per stage; a square at or above 2 gives a fraction bit.
    for (genvar k = 1; k <= FB; k++)
    begin : g_square
        logic [2*MW-1:0] sq;
        logic [MW:0]     sq_top;
        logic [MW-1:0]   y_next;
        logic [FB-1:0]   frac_next;

        always_comb
        begin
            sq        = y_reg[k-1] * y_reg[k-1];
            sq_top    = sq[2*MW-1:MW-1];
            y_next    = sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
            frac_next = frac_reg[k-1];
            frac_next[FB-k] = sq_top[MW];
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                y_reg[k]    <= y_next;
                frac_reg[k] <= frac_next;
                n_reg[k]    <= n_reg[k-1];
            end
        end
    end

    // Scale the Q16 logarithm by the channel constant.
    always_ff @(posedge clk)
    begin
        if (en[FB+1])
        begin
            prod_reg <= PW'({n_reg[FB], frac_reg[FB]}) * PW'(LOG_K);
        end
    end

    // Round to nearest and saturate at 255.
    always_comb
    begin
        rounded = {1'b0, prod_reg} + HALF;
        log_out = (|rounded[PW:RS+8]) ? 8'hFF : rounded[RS+7:RS];
    end

endmodule

`default_nettype wire

/* src/bayer_quad_to_rgb_gain.sv */
// Throughput: one quad per cycle while no output stall holds the pipeline back;
// each of the 16 fraction bits of the logarithm takes its own squaring stage,
// and every stage holds its own valid bit.
// A stalled output holds the pipeline back only as far as no empty stage is left.
// Reset: asynchronous, active low; clears all valid bits and sets the gain mode to 0
// with all three channels enabled.
`default_nettype none

`include "bayer_quad_to_rgb_gain_assert.svh"

module bayer_quad_to_rgb_gain (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire bqrg_pkg::quad_t                        in_data,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output bqrg_pkg::pixel_t                            out_data,
    input  wire logic                                   cfg_write,
    input  wire logic [bqrg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [bqrg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int SW = bqrg_pkg::SAMPLE_BITS;
    localparam int NS = bqrg_pkg::STAGES;
    localparam int LS = bqrg_pkg::LOG_STAGES;

    logic [bqrg_pkg::MODE_BITS-1:0] gain_mode_reg;
    logic                           red_enable_reg;
    logic                           green_enable_reg;
    logic                           blue_enable_reg;

    logic [NS-1:0]        valid_reg;
    logic [NS:0]          ready_vec;
    bqrg_pkg::quad_t      quad_reg;
    bqrg_pkg::pixel_t     lin_pixel;
    bqrg_pkg::pixel_t     lin_reg [1:LS];
    bqrg_pkg::pixel_t     out_reg;
    bqrg_pkg::pixel_t     out_next;
    logic [SW:0]          green_sum;
    logic [7:0]           log_red;
    logic [7:0]           log_green;
    logic [7:0]           log_blue;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_mode_reg    <= '0;
            red_enable_reg   <= 1'b1;
            green_enable_reg <= 1'b1;
            blue_enable_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bqrg_pkg::REG_GAIN_MODE:    gain_mode_reg    <= cfg_data;
                bqrg_pkg::REG_RED_ENABLE:   red_enable_reg   <= cfg_data[0];
                bqrg_pkg::REG_GREEN_ENABLE: green_enable_reg <= cfg_data[0];
                bqrg_pkg::REG_BLUE_ENABLE:  blue_enable_reg  <= cfg_data[0];
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    assign ready_vec[NS] = out_ready;
    for (genvar j = 0; j < NS; j++)
    begin : g_ready
        assign ready_vec[j] = !valid_reg[j] || ready_vec[j+1];
    end

    assign in_ready  = ready_vec[0];
    assign out_valid = valid_reg[NS-1];
    assign out_data  = out_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready_vec[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int j = 1; j < NS; j++)
            begin
                if (ready_vec[j])
                begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (ready_vec[0])
        begin
            quad_reg <= in_data;
        end
    end

    assign green_sum = (SW+1)'(quad_reg.green_top) + (SW+1)'(quad_reg.green_bottom);

    // Linear result, then delayed alongside the logarithm pipeline.
    bqrg_linear u_linear (
        .gain_mode (gain_mode_reg),
        .quad      (quad_reg),
        .pixel     (lin_pixel)
    );

    always_ff @(posedge clk)
    begin
        if (ready_vec[1])
        begin
            lin_reg[1] <= lin_pixel;
        end
        for (int j = 2; j <= LS; j++)
        begin
            if (ready_vec[j])
            begin
                lin_reg[j] <= lin_reg[j-1];
            end
        end
    end

    // Logarithm pipelines, one per channel.
    bqrg_log_unit #(
        .VALUE_BITS (SW),
        .LOG_K      (bqrg_pkg::LOG_K_RB)
    ) u_log_red (
        .clk     (clk),
        .en      (ready_vec[LS:1]),
        .value   (quad_reg.red_sample),
        .log_out (log_red)
    );

    bqrg_log_unit #(
        .VALUE_BITS (SW),
        .LOG_K      (bqrg_pkg::LOG_K_RB)
    ) u_log_blue (
        .clk     (clk),
        .en      (ready_vec[LS:1]),
        .value   (quad_reg.blue_sample),
        .log_out (log_blue)
    );

    bqrg_log_unit #(
        .VALUE_BITS (SW + 1),
        .LOG_K      (bqrg_pkg::LOG_K_G)
    ) u_log_green (
        .clk     (clk),
        .en      (ready_vec[LS:1]),
        .value   (green_sum),
        .log_out (log_green)
    );

    // Mode select and channel enables into the output register.
    always_comb
    begin
        if (gain_mode_reg >= bqrg_pkg::MODE_LOG)
        begin
            out_next.red_out   = log_red;
            out_next.green_out = log_green;
            out_next.blue_out  = log_blue;
        end
        else
        begin
            out_next = lin_reg[LS];
        end
        if (!red_enable_reg)
        begin
            out_next.red_out = '0;
        end
        if (!green_enable_reg)
        begin
            out_next.green_out = '0;
        end
        if (!blue_enable_reg)
        begin
            out_next.blue_out = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_vec[NS-1])
        begin
            out_reg <= out_next;
        end
    end

    // A request taken at the input occupies the first stage next cycle.
    `BQRG_ASSERT_NEXT(a_in_to_stage0, in_valid && in_ready, valid_reg[0], "accepted request lost")

    // A stalled stage keeps its item.
    `BQRG_ASSERT_NEXT(a_stall_hold, valid_reg[LS] && !ready_vec[LS], valid_reg[LS], "stalled item dropped")

    // With the output side ready the whole pipeline moves, so the input is ready too.
    `BQRG_ASSERT_SAME(a_ready_through, out_ready, in_ready, "input blocked while output ready")

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = bqrg_pkg::SAMPLE_BITS;
    localparam int CFG_W    = bqrg_pkg::CFG_DATA_BITS;

    // Scale factors c*ln2*65536 for the logarithmic mode.
    localparam logic [63:0] RB_SCALE    = 64'd1392673;
    localparam logic [63:0] GREEN_SCALE = 64'd1285513;

    // Cycles without any accepted request before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRESSURE_HOLD  = 300;
    localparam int RANDOM_PHASES  = 12;
    localparam int QUADS_PER_PHASE = 111;
    localparam int DIRECTED_COUNT = 22;

    // One directed vector: register setting, the quad, and an optional literal result.
    typedef struct packed {
        logic [bqrg_pkg::MODE_BITS-1:0] mode;
        logic                 red_en;
        logic                 green_en;
        logic                 blue_en;
        bqrg_pkg::quad_t      quad;
        logic                 given;
        bqrg_pkg::pixel_t     want;
    } vector_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    bqrg_pkg::quad_t in_data;
    logic out_valid;
    logic out_ready;
    bqrg_pkg::pixel_t out_data;
    logic cfg_write;
    logic [bqrg_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [bqrg_pkg::CFG_DATA_BITS-1:0] cfg_data;

    // Shadow copy of the configuration registers.
    logic [bqrg_pkg::MODE_BITS-1:0] gain_mode_q;
    logic red_on;
    logic green_on;
    logic blue_on;

    bqrg_pkg::pixel_t pending_pixels[$];
    vector_t directed_vectors[0:DIRECTED_COUNT-1];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int quads_sent;
    int pixels_checked;
    int error_count;
    int quiet_cycles;

    bayer_quad_to_rgb_gain uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Saturate to the 8-bit output range.
    function automatic logic [7:0] clip8(input logic [63:0] v);
        return (v > 64'd255) ? 8'hFF : v[7:0];
    endfunction

    // log2 of v in Q16: leading-one position plus 16 fraction bits by squaring.
    function automatic logic [63:0] log2_fixed(input logic [31:0] v);
        int unsigned n;
        int i;
        logic [63:0] y;
        logic [15:0] frac;
        n = 0;
        frac = '0;
        while (n < 31 && (v >> (n + 1)) != 0)
            n++;
        y = ({32'd0, v} << 31) >> n;
        y = y >> 1;
        for (i = 15; i >= 0; i--)
        begin
            y = (y * y) >> 30;
            if (y >= 64'h8000_0000)
            begin
                y = y >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(n) << 16) | 64'(frac);
    endfunction

    function automatic logic [7:0] log_scale(input logic [31:0] v, input logic [63:0] k);
        logic [63:0] l;
        if (v < 1)
            v = 1;
        l = log2_fixed(v);
        return clip8((l * k + 64'h8000_0000) >> 32);
    endfunction

    // Pixel that the current register setting should produce for a quad.
    function automatic bqrg_pkg::pixel_t expected_pixel(input bqrg_pkg::quad_t q);
        int unsigned gsum;
        int unsigned div;
        bqrg_pkg::pixel_t p;
        gsum = q.green_top + q.green_bottom;
        if (gain_mode_q >= bqrg_pkg::MODE_LOG)
        begin
            p.blue_out  = log_scale(q.blue_sample, RB_SCALE);
            p.green_out = log_scale(gsum, GREEN_SCALE);
            p.red_out   = log_scale(q.red_sample, RB_SCALE);
        end
        else
        begin
            div = 16 >> gain_mode_q;
            p.blue_out  = clip8((q.blue_sample + div / 2) / div);
            p.green_out = clip8((gsum + div) / (2 * div));
            p.red_out   = clip8((q.red_sample + div / 2) / div);
        end
        if (!blue_on)
            p.blue_out = 8'd0;
        if (!green_on)
            p.green_out = 8'd0;
        if (!red_on)
            p.red_out = 8'd0;
        return p;
    endfunction

    // Sample values weighted toward the interesting corners of each mode.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            6: v = SAMPLE_W'($urandom_range(0, 40));
            7: v = SAMPLE_W'($urandom_range(4040, 4095));
            8: v = SAMPLE_W'((32'd1 << $urandom_range(0, 11)) + $urandom_range(0, 2) - 32'd1);
            9: v = SAMPLE_W'(($urandom_range(0, 255) << 4) + $urandom_range(6, 9));
            default: v = SAMPLE_W'($urandom_range(0, 4095));
        endcase
        return v;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Wait for every outstanding pixel and let the pipeline run empty.
    task automatic wait_idle();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (bqrg_pkg::STAGES + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bqrg_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [bqrg_pkg::CFG_DATA_BITS-1:0] data);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Bring the registers to a new setting; only changed registers are written.
    task automatic apply_settings(input logic [bqrg_pkg::MODE_BITS-1:0] mode, input logic ren,
                                  input logic gen, input logic ben);
        if (mode != gain_mode_q || ren != red_on || gen != green_on || ben != blue_on)
        begin
            wait_idle();
            if (mode != gain_mode_q)
                write_reg(bqrg_pkg::REG_GAIN_MODE, mode);
            if (ren != red_on)
                write_reg(bqrg_pkg::REG_RED_ENABLE, CFG_W'(ren));
            if (gen != green_on)
                write_reg(bqrg_pkg::REG_GREEN_ENABLE, CFG_W'(gen));
            if (ben != blue_on)
                write_reg(bqrg_pkg::REG_BLUE_ENABLE, CFG_W'(ben));
            gain_mode_q = mode;
            red_on = ren;
            green_on = gen;
            blue_on = ben;
        end
    endtask

    // Offer one quad request and record its expected pixel once accepted.
    task automatic send_quad(input bqrg_pkg::quad_t q, input logic given,
                             input bqrg_pkg::pixel_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = q;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_pixels.push_back(given ? want : expected_pixel(q));
        quads_sent++;
        @(negedge clk);
    endtask

    // Receiver: random stalls, a long hold on request, and the pixel check.
    initial
    begin
        bqrg_pkg::pixel_t want;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: pixel %h with no request outstanding", $time, out_data);
                    error_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    compare_field("blue_out", want.blue_out, out_data.blue_out);
                    compare_field("green_out", want.green_out, out_data.green_out);
                    compare_field("red_out", want.red_out, out_data.red_out);
                    pixels_checked++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic [bqrg_pkg::MODE_BITS-1:0] mode_plan[RANDOM_PHASES];
        vector_t v;
        bqrg_pkg::quad_t q;
        int i;
        int s;
        logic all_on;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        quads_sent = 0;
        pixels_checked = 0;
        error_count = 0;
        quiet_cycles = 0;
        gain_mode_q = 3'd0;
        red_on = 1'b1;
        green_on = 1'b1;
        blue_on = 1'b1;

        // Directed vectors: mode, red/green/blue enable, quad {gt, r, b, gb}, literal pixel {b, g, r}.
        directed_vectors = '{
            '{3'd0, 1'b1, 1'b1, 1'b1, '{12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
            '{3'd0, 1'b1, 1'b1, 1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
              1'b1, '{8'd255, 8'd255, 8'd255}},
            '{3'd0, 1'b1, 1'b1, 1'b1, '{12'd15, 12'd8, 12'd7, 12'd0}, 1'b0, '0},
            '{3'd0, 1'b1, 1'b1, 1'b1, '{12'd16, 12'd24, 12'd23, 12'd15}, 1'b0, '0},
            '{3'd1, 1'b1, 1'b1, 1'b1, '{12'd2048, 12'd2047, 12'd4, 12'd5}, 1'b0, '0},
            '{3'd2, 1'b1, 1'b1, 1'b1, '{12'd100, 12'd1000, 12'd2000, 12'd3000}, 1'b0, '0},
            '{3'd3, 1'b1, 1'b1, 1'b1, '{12'd1, 12'd1, 12'd1, 12'd1}, 1'b0, '0},
            '{bqrg_pkg::MODE_LIN_BASE, 1'b1, 1'b1, 1'b1, '{12'd50, 12'd200, 12'd100, 12'd52},
              1'b1, '{8'd100, 8'd51, 8'd200}},
            '{bqrg_pkg::MODE_LIN_BASE, 1'b1, 1'b1, 1'b1,
              '{12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, '{8'd255, 8'd255, 8'd255}},
            '{bqrg_pkg::MODE_LIN_BASE, 1'b1, 1'b1, 1'b1, '{12'd0, 12'd255, 12'd254, 12'd1},
              1'b1, '{8'd254, 8'd1, 8'd255}},
            '{bqrg_pkg::MODE_LOG, 1'b1, 1'b1, 1'b1, '{12'd0, 12'd0, 12'd0, 12'd0},
              1'b1, '{8'd0, 8'd0, 8'd0}},
            '{bqrg_pkg::MODE_LOG, 1'b1, 1'b1, 1'b1, '{12'd1, 12'd1, 12'd1, 12'd0},
              1'b1, '{8'd0, 8'd0, 8'd0}},
            '{bqrg_pkg::MODE_LOG, 1'b1, 1'b1, 1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
              1'b0, '0},
            '{bqrg_pkg::MODE_LOG, 1'b1, 1'b1, 1'b1, '{12'd2048, 12'd1024, 12'd2, 12'd1},
              1'b0, '0},
            '{bqrg_pkg::MODE_LOG, 1'b1, 1'b1, 1'b1, '{12'd3, 12'd4000, 12'd77, 12'd4094},
              1'b0, '0},
            '{bqrg_pkg::MODE_LOG + 3'd1, 1'b1, 1'b1, 1'b1,
              '{12'd100, 12'd200, 12'd300, 12'd400}, 1'b0, '0},
            '{bqrg_pkg::MODE_LOG + 3'd2, 1'b1, 1'b1, 1'b1,
              '{12'd4095, 12'd1, 12'd4095, 12'd0}, 1'b0, '0},
            '{3'd0, 1'b0, 1'b1, 1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
              1'b1, '{8'd255, 8'd255, 8'd0}},
            '{3'd0, 1'b1, 1'b0, 1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
              1'b1, '{8'd255, 8'd0, 8'd255}},
            '{3'd0, 1'b1, 1'b1, 1'b0, '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
              1'b1, '{8'd0, 8'd255, 8'd255}},
            '{bqrg_pkg::MODE_LOG, 1'b0, 1'b0, 1'b0, '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
              1'b1, '{8'd0, 8'd0, 8'd0}},
            '{3'd2, 1'b1, 1'b1, 1'b1, '{12'd1234, 12'd567, 12'd890, 12'd3210}, 1'b0, '0}
        };
        mode_plan = '{3'd0, bqrg_pkg::MODE_LOG, bqrg_pkg::MODE_LIN_BASE, 3'd1,
                      bqrg_pkg::MODE_LOG + 3'd2, 3'd2, bqrg_pkg::MODE_LOG, 3'd3,
                      bqrg_pkg::MODE_LOG + 3'd1, 3'd0, bqrg_pkg::MODE_LIN_BASE,
                      bqrg_pkg::MODE_LOG};

        // Reset once, released on a falling edge.
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, no idling on either side.
        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            v = directed_vectors[i];
            in_valid = 1'b0;
            apply_settings(v.mode, v.red_en, v.green_en, v.blue_en);
            send_quad(v.quad, v.given, v.want);
        end

        // Random part: one register setting per phase, idling profile rotating.
        for (s = 0; s < RANDOM_PHASES; s++)
        begin
            in_valid = 1'b0;
            all_on = (s == 0 || s == 5 || s == RANDOM_PHASES - 1);
            apply_settings(mode_plan[s],
                           all_on || ($urandom_range(0, 4) != 0),
                           all_on || ($urandom_range(0, 4) != 0),
                           all_on || ($urandom_range(0, 4) != 0));
            case (s % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            // Hold the output off long enough that the pipeline fills and backs up.
            if (s == 2)
                hold_left = PRESSURE_HOLD;
            for (i = 0; i < QUADS_PER_PHASE; i++)
            begin
                q.green_top    = random_sample();
                q.red_sample   = random_sample();
                q.blue_sample  = random_sample();
                q.green_bottom = random_sample();
                send_quad(q, 1'b0, '0);
            end
        end

        // Drain and let any stray output show up.
        in_valid = 1'b0;
        recv_stall_pct = 0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (bqrg_pkg::STAGES + 10) @(posedge clk);

        $display("Sent %0d quads and checked %0d pixels across gain modes 0-7,", quads_sent,
                 pixels_checked);
        $display("channel enables on and off, idling on both sides and a backed-up pipeline.");
        if (error_count == 0 && pending_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
